// ===== sv/ist_pkg.sv =====
// Shared types and constants for the integer set table.
`default_nettype none
package ist_pkg;

  // Number of cells in the table
  localparam int CAPACITY = 128;
  // Width of the member counter (holds 0..CAPACITY)
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Operation codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic       changed;
    logic       full_reject;
    logic [7:0] entry_count;
    logic       is_empty;
  } out_item_t;

  // Controls broadcast to every cell
  typedef struct packed {
    logic        cmp_en;    // capture compare result against cmp_key
    logic        shift_en;  // remove: cells at or past the hit take neighbor value
    logic [31:0] cmp_key;
    logic [31:0] wr_data;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== sv/ist_cell.sv =====
// One table cell: holds a member, compares it with the key and shifts on remove.
`default_nettype none
module ist_cell (
  input  wire logic              clk,
  input  wire ist_pkg::cell_ctl_t ctl,
  input  wire logic              live,       // cell index is below the member count
  input  wire logic              wr_en,      // append target
  input  wire logic              hit_in,     // a match sits in an earlier cell
  input  wire logic [31:0]       next_value, // value of the following cell
  output logic [31:0]            value,
  output logic                   hit_out
);
  import ist_pkg::*;

  logic [31:0] value_r, value_nxt;
  logic        match_r;

  // Remove shifts down every cell from the matching one onward
  always_comb begin
    value_nxt = value_r;
    if (wr_en) begin
      value_nxt = ctl.wr_data;
    end else if (ctl.shift_en && (hit_in || match_r)) begin
      value_nxt = next_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (ctl.cmp_en) begin
      match_r <= live && (value_r == ctl.cmp_key);
    end
  end

  assign value   = value_r;
  assign hit_out = hit_in || match_r;

endmodule
`default_nettype wire

// ===== sv/integer_set_table_core.sv =====
// Top level of the integer set table: control, member counter and the cell chain.
`default_nettype none
// Bounded set of distinct 32-bit integers kept in insertion order, one value per
// cell in a chain of CAPACITY cells. Each operation goes as follows: at the
// edge that accepts an item each cell compares its member with the value, and
// in the following cycle the hit ripples along the chain while the table
// shifts down (remove) or appends at the end (add). The result strobes on
// out_valid for one cycle right after that, with busy already low, so a new
// item may be started in the same cycle the previous result is shown. The
// receiver cannot stall, so results must be taken as they appear. No clearing
// pass is needed after reset; clear is handled like any other item.
module integer_set_table_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire ist_pkg::in_item_t  in_item,
  output logic                    busy,
  output logic                    out_valid,
  output ist_pkg::out_item_t      out_item
);
  import ist_pkg::*;

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t           state_r;
  logic [1:0]       mode_r;
  logic [31:0]      key_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  out_item_t        out_item_r, out_item_nxt;

  cell_ctl_t        ctl;
  logic             accept;
  logic             exec;
  logic             found;
  logic             do_append;
  logic             do_remove;
  logic             full;

  logic [31:0]      cell_val [CAPACITY];
  logic [CAPACITY:0] hit_chain;

  assign accept = start && (state_r == ST_IDLE);
  assign exec   = (state_r == ST_EXEC);
  assign busy   = exec;
  assign found  = hit_chain[CAPACITY];
  assign full   = (count_r >= CNT_W'(CAPACITY));

  assign do_append = exec && (mode_r == OP_ADD) && !found && !full;
  assign do_remove = exec && (mode_r == OP_REMOVE) && found;

  // Broadcast controls
  always_comb begin
    ctl.cmp_en   = accept;
    ctl.shift_en = do_remove;
    ctl.cmp_key  = in_item.value;
    ctl.wr_data  = key_r;
  end

  // Cell chain
  assign hit_chain[0] = 1'b0;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0] nbr;
    if (i == CAPACITY - 1) begin : g_last
      assign nbr = cell_val[i];
    end else begin : g_mid
      assign nbr = cell_val[i+1];
    end
    ist_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .live       (CNT_W'(i) < count_r),
      .wr_en      (do_append && (count_r == CNT_W'(i))),
      .hit_in     (hit_chain[i]),
      .next_value (nbr),
      .value      (cell_val[i]),
      .hit_out    (hit_chain[i+1])
    );
  end

  // Result and next count
  always_comb begin
    count_nxt                = count_r;
    out_item_nxt.found       = found;
    out_item_nxt.changed     = 1'b0;
    out_item_nxt.full_reject = 1'b0;
    case (mode_r)
      OP_ADD: begin
        if (!found) begin
          if (full) begin
            out_item_nxt.full_reject = 1'b1;
          end else begin
            count_nxt            = count_r + CNT_W'(1);
            out_item_nxt.changed = 1'b1;
          end
        end
      end
      OP_REMOVE: begin
        if (found) begin
          count_nxt            = count_r - CNT_W'(1);
          out_item_nxt.changed = 1'b1;
        end
      end
      OP_LOOKUP: begin
        count_nxt = count_r;
      end
      OP_CLEAR: begin
        count_nxt            = '0;
        out_item_nxt.found   = 1'b0;
        out_item_nxt.changed = 1'b1;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
    out_item_nxt.entry_count = 8'(count_nxt);
    out_item_nxt.is_empty    = (count_nxt == '0);
  end

  // Sequencer, counter and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_r     <= ST_IDLE;
          count_r     <= count_nxt;
          out_valid_r <= 1'b1;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
    if (accept) begin
      mode_r <= in_item.mode;
      key_r  <= in_item.value;
    end
    if (exec) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Checks
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted item did not enter execute");
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy))
    else $error("execute cycle did not produce a result");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("member count above capacity");
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.is_empty == (count_r == '0)))
    else $error("empty flag disagrees with member count");
  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.full_reject |-> (count_r == CNT_W'(CAPACITY)) && !out_item.changed)
    else $error("reject reported while table not full");

endmodule
`default_nettype wire
